@@ hw/rtl/aabb_overlap_push_out_assert.svh @@
// Assertion macros shared by the push-out block.
`ifndef AABB_OVERLAP_PUSH_OUT_ASSERT_SVH
`define AABB_OVERLAP_PUSH_OUT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AOP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AOP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/aop_pkg.sv @@
// Types and constants of the box overlap push-out block.
`timescale 1ns / 1ps
`default_nettype none

package aop_pkg;

    localparam int COORD_W    = 32;
    localparam int SIZE_W     = 31;
    localparam int STEP_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;
    localparam int IN_W       = 288;
    localparam int OUT_W      = 104;

    localparam int MAX_ROUNDS = 4096;
    localparam int COORD_BITS = 32;

    localparam int AMT_W  = STEP_W + $clog2(MAX_ROUNDS + 1);
    localparam int CALC_W = ((COORD_W > AMT_W) ? COORD_W : AMT_W) + 2;
    localparam int RND_W  = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;

    localparam int SAT_EXP = (COORD_BITS < CALC_W) ? COORD_BITS - 1 : CALC_W - 1;
    localparam logic signed [CALC_W-1:0] SAT_ONE = 1;
    localparam logic signed [CALC_W-1:0] SAT_HI  = (SAT_ONE <<< SAT_EXP) - SAT_ONE;
    localparam logic signed [CALC_W-1:0] SAT_LO  = -SAT_HI - SAT_ONE;

    localparam logic [SIZE_W-1:0] SIZE_RST = 31'd65536;
    localparam logic [STEP_W-1:0] STEP_RST = 16'd6554;

    localparam logic [2:0] K_LAST = 3'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OWN_SIZE_X,
        REG_OWN_SIZE_Y,
        REG_OWN_SIZE_Z,
        REG_PUSH_STEP
    } t_cfg_reg;

    typedef enum logic [1:0] {
        AX_X,
        AX_Y,
        AX_Z
    } t_axis;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BOUNDS,
        ST_CHECK,
        ST_SEARCH,
        ST_PUSH
    } t_state;

    typedef struct packed {
        logic load;
        logic bounds;
        logic check;
        logic step;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic hit_now;
        logic free;
        logic last_k;
        logic last_round;
        logic out_room;
    } t_sts;

endpackage

`default_nettype wire

@@ hw/rtl/aop_ctrl.sv @@
// Sequencing state machine of the box overlap push-out block.
`timescale 1ns / 1ps
`default_nettype none

module aop_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire aop_pkg::t_sts i_sts,
    output aop_pkg::t_cmd      o_cmd
);

    aop_pkg::t_state r_state;
    aop_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aop_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            aop_pkg::ST_IDLE: begin
                if (i_s_tvalid) n_state = aop_pkg::ST_BOUNDS;
            end
            aop_pkg::ST_BOUNDS: begin
                n_state = aop_pkg::ST_CHECK;
            end
            aop_pkg::ST_CHECK: begin
                n_state = i_sts.hit_now ? aop_pkg::ST_SEARCH : aop_pkg::ST_PUSH;
            end
            aop_pkg::ST_SEARCH: begin
                if (i_sts.free || (i_sts.last_k && i_sts.last_round)) begin
                    n_state = aop_pkg::ST_PUSH;
                end
            end
            aop_pkg::ST_PUSH: begin
                if (i_sts.out_room) n_state = aop_pkg::ST_IDLE;
            end
            default: begin
                n_state = aop_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            aop_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            aop_pkg::ST_BOUNDS: begin
                o_cmd.bounds = 1'b1;
            end
            aop_pkg::ST_CHECK: begin
                o_cmd.check = 1'b1;
            end
            aop_pkg::ST_SEARCH: begin
                o_cmd.step = 1'b1;
            end
            aop_pkg::ST_PUSH: begin
                o_cmd.push = i_sts.out_room;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/aop_dp.sv @@
// Datapath of the box overlap push-out block: registers, trial unit, output stage.
`timescale 1ns / 1ps
`default_nettype none
`include "aabb_overlap_push_out_assert.svh"

module aop_dp (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [aop_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [aop_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [aop_pkg::IN_W-1:0]       i_s_tdata,
    input  wire aop_pkg::t_cmd                  i_cmd,
    output aop_pkg::t_sts                       o_sts,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic [aop_pkg::OUT_W-1:0]           o_m_tdata
);

    localparam int CW = aop_pkg::CALC_W;
    localparam int PW = aop_pkg::COORD_W;
    localparam int SW = aop_pkg::SIZE_W;

    // configuration
    logic [SW-1:0]                r_own_size_x;
    logic [SW-1:0]                r_own_size_y;
    logic [SW-1:0]                r_own_size_z;
    logic [aop_pkg::STEP_W-1:0]   r_push_step;

    // item
    logic signed [PW-1:0] r_own_x, r_own_y, r_own_z;
    logic signed [PW-1:0] r_oth_x, r_oth_y, r_oth_z;
    logic [SW-1:0]        r_osz_x, r_osz_y, r_osz_z;
    logic signed [CW-1:0] r_hi_x, r_hi_y, r_hi_z;
    logic signed [CW-1:0] r_lo_x, r_lo_y, r_lo_z;

    // search
    logic [aop_pkg::AMT_W-1:0] r_amt;
    logic [2:0]                r_k;
    logic [aop_pkg::RND_W-1:0] r_round;
    logic                      r_hit;
    logic                      r_gave;
    logic signed [PW-1:0]      r_res_x, r_res_y, r_res_z;

    // output stage
    logic                 r_out_valid;
    logic                 r_out_hit;
    logic                 r_out_gave;
    logic signed [PW-1:0] r_out_x, r_out_y, r_out_z;

    function automatic logic signed [CW-1:0] sext(input logic signed [PW-1:0] v);
        return {{(CW - PW){v[PW-1]}}, v};
    endfunction

    function automatic logic signed [CW-1:0] half_sum(input logic [SW-1:0] a,
                                                      input logic [SW-1:0] b);
        logic [SW:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return {{(CW - SW){1'b0}}, sum[SW:1]};
    endfunction

    // bounds: the own centre overlaps on an axis when lo <= c <= hi
    logic signed [CW-1:0] w_half_x, w_half_y, w_half_z;
    assign w_half_x = half_sum(r_own_size_x, r_osz_x);
    assign w_half_y = half_sum(r_own_size_y, r_osz_y);
    assign w_half_z = half_sum(r_own_size_z, r_osz_z);

    logic w_in_x, w_in_y, w_in_z;
    assign w_in_x = (sext(r_own_x) >= r_lo_x) && (sext(r_own_x) <= r_hi_x);
    assign w_in_y = (sext(r_own_y) >= r_lo_y) && (sext(r_own_y) <= r_hi_y);
    assign w_in_z = (sext(r_own_z) >= r_lo_z) && (sext(r_own_z) <= r_hi_z);

    // trial order per round: +x, -x, +z, -z, +y, -y
    aop_pkg::t_axis       w_axis;
    logic signed [PW-1:0] w_own_ax;
    logic signed [CW-1:0] w_hi_ax, w_lo_ax;
    logic signed [CW-1:0] w_amt_e, w_sum, w_trial;
    logic                 w_free;

    always_comb begin
        unique case (r_k[2:1])
            2'b00:   w_axis = aop_pkg::AX_X;
            2'b01:   w_axis = aop_pkg::AX_Z;
            2'b10:   w_axis = aop_pkg::AX_Y;
            default: w_axis = aop_pkg::AX_X;
        endcase
    end

    always_comb begin
        unique case (w_axis)
            aop_pkg::AX_Y: begin
                w_own_ax = r_own_y;
                w_hi_ax  = r_hi_y;
                w_lo_ax  = r_lo_y;
            end
            aop_pkg::AX_Z: begin
                w_own_ax = r_own_z;
                w_hi_ax  = r_hi_z;
                w_lo_ax  = r_lo_z;
            end
            default: begin
                w_own_ax = r_own_x;
                w_hi_ax  = r_hi_x;
                w_lo_ax  = r_lo_x;
            end
        endcase
    end

    assign w_amt_e = {{(CW - aop_pkg::AMT_W){1'b0}}, r_amt};
    assign w_sum   = r_k[0] ? (sext(w_own_ax) - w_amt_e) : (sext(w_own_ax) + w_amt_e);

    always_comb begin
        priority if (w_sum > aop_pkg::SAT_HI) begin
            w_trial = aop_pkg::SAT_HI;
        end else if (w_sum < aop_pkg::SAT_LO) begin
            w_trial = aop_pkg::SAT_LO;
        end else begin
            w_trial = w_sum;
        end
    end

    // the other two axes still overlap, so only the moved axis decides
    assign w_free = (w_trial > w_hi_ax) || (w_trial < w_lo_ax);

    assign o_sts.hit_now    = w_in_x && w_in_y && w_in_z;
    assign o_sts.free       = w_free;
    assign o_sts.last_k     = (r_k == aop_pkg::K_LAST);
    assign o_sts.last_round = (r_round == aop_pkg::RND_W'(aop_pkg::MAX_ROUNDS - 1));
    assign o_sts.out_room   = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_size_x <= aop_pkg::SIZE_RST;
            r_own_size_y <= aop_pkg::SIZE_RST;
            r_own_size_z <= aop_pkg::SIZE_RST;
            r_push_step  <= aop_pkg::STEP_RST;
        end else if (i_cfg_we) begin
            unique case (aop_pkg::t_cfg_reg'(i_cfg_idx))
                aop_pkg::REG_OWN_SIZE_X: r_own_size_x <= i_cfg_data;
                aop_pkg::REG_OWN_SIZE_Y: r_own_size_y <= i_cfg_data;
                aop_pkg::REG_OWN_SIZE_Z: r_own_size_z <= i_cfg_data;
                aop_pkg::REG_PUSH_STEP:  r_push_step  <= i_cfg_data[aop_pkg::STEP_W-1:0];
                default:                 r_push_step  <= r_push_step;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_own_x <= i_s_tdata[31:0];
            r_own_y <= i_s_tdata[63:32];
            r_own_z <= i_s_tdata[95:64];
            r_oth_x <= i_s_tdata[127:96];
            r_oth_y <= i_s_tdata[159:128];
            r_oth_z <= i_s_tdata[191:160];
            r_osz_x <= i_s_tdata[222:192];
            r_osz_y <= i_s_tdata[253:223];
            r_osz_z <= i_s_tdata[284:254];
            r_gave  <= 1'b0;
        end
        if (i_cmd.bounds) begin
            r_hi_x <= sext(r_oth_x) + w_half_x;
            r_lo_x <= sext(r_oth_x) - w_half_x;
            r_hi_y <= sext(r_oth_y) + w_half_y;
            r_lo_y <= sext(r_oth_y) - w_half_y;
            r_hi_z <= sext(r_oth_z) + w_half_z;
            r_lo_z <= sext(r_oth_z) - w_half_z;
        end
        if (i_cmd.check) begin
            r_hit   <= o_sts.hit_now;
            r_amt   <= {{(aop_pkg::AMT_W - aop_pkg::STEP_W){1'b0}}, r_push_step};
            r_res_x <= r_own_x;
            r_res_y <= r_own_y;
            r_res_z <= r_own_z;
        end
        if (i_cmd.step) begin
            if (w_free) begin
                unique case (w_axis)
                    aop_pkg::AX_Y: r_res_y <= w_trial[PW-1:0];
                    aop_pkg::AX_Z: r_res_z <= w_trial[PW-1:0];
                    default:       r_res_x <= w_trial[PW-1:0];
                endcase
            end else if (o_sts.last_k) begin
                r_amt <= r_amt + {{(aop_pkg::AMT_W - aop_pkg::STEP_W){1'b0}}, r_push_step};
                if (o_sts.last_round) r_gave <= 1'b1;
            end
        end
        if (i_cmd.push) begin
            r_out_hit  <= r_hit;
            r_out_gave <= r_gave;
            r_out_x    <= r_res_x;
            r_out_y    <= r_res_y;
            r_out_z    <= r_res_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= '0;
            r_round     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.check) begin
                r_k     <= '0;
                r_round <= '0;
            end else if (i_cmd.step && !w_free) begin
                if (o_sts.last_k) begin
                    r_k     <= '0;
                    r_round <= r_round + aop_pkg::RND_W'(1);
                end else begin
                    r_k <= r_k + 3'd1;
                end
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'b0, r_out_gave, r_out_z, r_out_y, r_out_x, r_out_hit};

    `AOP_ASSERT_IMP(a_gave_needs_hit, i_clk, i_rst_n, r_out_valid && r_out_gave, r_out_hit)
    `AOP_ASSERT_NXT(a_push_fills_out, i_clk, i_rst_n, i_cmd.push, r_out_valid)
    `AOP_ASSERT_NXT(a_free_not_gave, i_clk, i_rst_n, i_cmd.step && w_free, !r_gave)
    `AOP_ASSERT_IMP(a_k_in_round, i_clk, i_rst_n, 1'b1, r_k <= aop_pkg::K_LAST)

endmodule

`default_nettype wire

@@ hw/rtl/aabb_overlap_push_out.sv @@
// Top level of the 3D box overlap test with push-out search.
//
// One item at a time. An item whose boxes do not overlap has its result in the
// output register after the bounds, overlap check and output steps, and the
// next item is accepted once the block is back in idle. An overlapping item
// adds a search that tries shifted positions in the order +x, -x, +z, -z, +y,
// -y with the push amount growing by push_step each round, until a free
// position is found or the search gives up after MAX_ROUNDS rounds. The search
// uses the single shared trial comparator, which tests one shifted position per
// cycle. A finished result sits in the output register while the next item is
// accepted; the block only stalls in its output step while the previous result
// is still not taken.
`timescale 1ns / 1ps
`default_nettype none

module aabb_overlap_push_out (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [aop_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [aop_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // own_x, own_y, own_z, other_x, other_y, other_z,
    // other_size_x, other_size_y, other_size_z, zero pad
    input  wire logic [aop_pkg::IN_W-1:0]       i_s_tdata,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // overlapping, free_x, free_y, free_z, gave_up, zero pad
    output logic [aop_pkg::OUT_W-1:0]           o_m_tdata
);

    aop_pkg::t_cmd w_cmd;
    aop_pkg::t_sts w_sts;

    aop_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    aop_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tdata  (i_s_tdata),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

`default_nettype wire
